### design/cbm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_pkg: shared types and constants of the cartridge bank mapper
// Item layouts, command codes, register addresses and sequencer states.
// ----------------------------------------------------------------------------
package cbm_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE    = 2'd0,
    CMD_TICK     = 2'd1,
    CMD_POWER_UP = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISK,
    ST_MOD,
    ST_CUP,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] address;
    logic [7:0]  data;
    logic [9:0]  cycles;
  } req_item_t;

  typedef struct packed {
    logic [5:0] prg_bank_slot0;
    logic [5:0] prg_bank_slot1;
    logic [5:0] prg_bank_slot2;
    logic [5:0] prg_bank_slot3;
    logic       prg_wr_en;
    logic [1:0] chr_bank;
    logic       chr_wr_en;
    logic [1:0] mirroring;
    logic       irq;
    logic       write_through;
  } rsp_item_t;

  // Configuration register indexes.
  localparam logic CFG_BOARD_VARIANT = 1'b0;
  localparam logic CFG_VERTICAL      = 1'b1;

  // Register window on the CPU bus.
  localparam logic [15:0] ADDR_REG_LO     = 16'h4020;
  localparam logic [15:0] ADDR_REG_HI     = 16'h47FF;
  localparam logic [15:0] ADDR_IRQ_ACK    = 16'h4024;
  localparam logic [15:0] ADDR_TIMER_CTRL = 16'h4025;
  localparam logic [15:0] ADDR_COUNT_LO   = 16'h4100;
  localparam logic [15:0] ADDR_COUNT_HI   = 16'h4101;
  localparam logic [15:0] ADDR_MODE_ONE   = 16'h42FC;
  localparam logic [15:0] ADDR_MODE_TWO   = 16'h43FC;

  // Latch banking modes held in mode_one bits 7..5.
  localparam logic [2:0] MODE_32K_LOW  = 3'd0;
  localparam logic [2:0] MODE_32K_MID  = 3'd1;
  localparam logic [2:0] MODE_16K_HIGH = 3'd2;
  localparam logic [2:0] MODE_16K_TOP  = 3'd3;
  localparam logic [2:0] MODE_32K_QUAD = 3'd4;
  localparam logic [2:0] MODE_FIXED    = 3'd5;
  localparam logic [2:0] MODE_NIBBLE   = 3'd6;
  localparam logic [2:0] MODE_NIBBLE_E = 3'd7;

  localparam logic [15:0] DISK_MOD       = 16'd448;
  localparam logic [7:0]  TIMER_CLR_MASK = 8'h42;
  localparam logic [2:0]  MOD_STEPS_TOP  = 3'd6;

endpackage
`default_nettype wire

### design/cbm_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_if: handshake channels of the cartridge bank mapper
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface cbm_req_if;
  logic               valid;
  logic               ready;
  cbm_pkg::req_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface cbm_rsp_if;
  logic               valid;
  logic               ready;
  cbm_pkg::rsp_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface
`default_nettype wire

### design/cartridge_bank_mapper_with_irq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_irq: program/character bank mapper with timers
// Decodes CPU bus writes, runs the disk and count-up interrupt timers on
// cycle ticks and reports the bank mapping after every item.
// ----------------------------------------------------------------------------
// A bus write, power-up or ignored item is applied in the cycle it is
// accepted, and its result item is loaded into the output register once
// that register is free. A tick does the disk add, then, when the disk timer
// fires, seven restoring steps of the modulo-448 reduction (448 shifted down
// from 28672) and the count-up add, as one 17-bit add/subtract unit does them
// in turn. The block takes one item at a time and is ready only in its idle
// state; a waiting result item does not block the next item from entering.
module cartridge_bank_mapper_with_irq #(
  parameter int BANK_BITS = 6
) (
  input  wire logic       clk,
  input  wire logic       rst,
  cbm_req_if.sink         request,
  cbm_rsp_if.source       result,
  input  wire logic       cfg_write,
  input  wire logic       cfg_index,
  input  wire logic [2:0] cfg_data
);

  localparam logic [5:0] SLOT_MASK = 6'((1 << BANK_BITS) - 1);

  cbm_pkg::state_t state, state_next;

  logic                 board_variant;
  logic [2:0]           variant;
  logic                 vertical;
  logic [7:0]           mode_one;
  logic [7:0]           mode_two;
  logic [BANK_BITS-1:0] bank_regs [4];
  logic [1:0]           chr_bank_reg;
  logic [7:0]           data_latch;
  logic [7:0]           timer_control;
  logic [15:0]          disk_counter;
  logic [15:0]          countup_counter;
  logic                 irq_flag;
  logic                 wt_pending;
  logic [9:0]           tick_cycles;
  logic [11:0]          tick_cycles3;
  logic [2:0]           mod_step;

  logic                 rsp_valid;
  cbm_pkg::rsp_item_t   rsp_item;

  logic                 accept;
  logic [15:0]          alu_a, alu_b;
  logic                 alu_sub;
  logic [16:0]          alu_res;
  logic                 disk_fire;
  logic [7:0]           bank_value;
  logic [5:0]           slot [4];
  logic [7:0]           bank_wide [4];

  assign board_variant = 1'b0;
  assign accept        = request.valid && request.ready;
  assign request.ready = (state == cbm_pkg::ST_IDLE);
  assign result.valid  = rsp_valid;
  assign result.item   = rsp_item;
  assign bank_value    = {2'b00, request.item.data[7:2]};

  // Shared add/subtract unit.
  always_comb begin
    alu_a   = 16'd0;
    alu_b   = 16'd0;
    alu_sub = 1'b0;
    case (state)
      cbm_pkg::ST_DISK: begin
        alu_a = disk_counter;
        alu_b = 16'(tick_cycles3);
      end
      cbm_pkg::ST_MOD: begin
        alu_a   = disk_counter;
        alu_b   = cbm_pkg::DISK_MOD << mod_step;
        alu_sub = 1'b1;
      end
      cbm_pkg::ST_CUP: begin
        alu_a = countup_counter;
        alu_b = 16'(tick_cycles);
      end
      default: begin
      end
    endcase
    alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) : ({1'b0, alu_a} + {1'b0, alu_b});
  end

  assign disk_fire = timer_control[7] && !alu_res[15] && (alu_res[15:0] >= cbm_pkg::DISK_MOD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cbm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cbm_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (request.item.command == cbm_pkg::CMD_TICK) ?
                       cbm_pkg::ST_DISK : cbm_pkg::ST_FIN;
        end
      end
      cbm_pkg::ST_DISK: begin
        state_next = disk_fire ? cbm_pkg::ST_MOD : cbm_pkg::ST_CUP;
      end
      cbm_pkg::ST_MOD: begin
        if (mod_step == 3'd0) begin
          state_next = cbm_pkg::ST_CUP;
        end
      end
      cbm_pkg::ST_CUP: begin
        state_next = cbm_pkg::ST_FIN;
      end
      cbm_pkg::ST_FIN: begin
        if (!rsp_valid || result.ready) begin
          state_next = cbm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cbm_pkg::ST_IDLE;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      variant  <= 3'd0;
      vertical <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        cbm_pkg::CFG_BOARD_VARIANT: variant  <= cfg_data;
        cbm_pkg::CFG_VERTICAL:      vertical <= cfg_data[0];
      endcase
    end
  end

  // Mapper state, including the power-up load and the timer steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_one        <= {board_variant, board_variant, board_variant, 5'b00011};
      mode_two        <= 8'h03;
      bank_regs[0]    <= BANK_BITS'(8'h1C);
      bank_regs[1]    <= BANK_BITS'(8'h1D);
      bank_regs[2]    <= BANK_BITS'(8'h1E);
      bank_regs[3]    <= BANK_BITS'(8'h1F);
      chr_bank_reg    <= 2'd0;
      data_latch      <= 8'd0;
      timer_control   <= 8'd0;
      disk_counter    <= 16'd0;
      countup_counter <= 16'd0;
      irq_flag        <= 1'b0;
      wt_pending      <= 1'b0;
      mod_step        <= 3'd0;
    end else begin
      unique case (state)
        cbm_pkg::ST_IDLE: begin
          if (accept) begin
            wt_pending   <= 1'b0;
            tick_cycles  <= request.item.cycles;
            tick_cycles3 <= {1'b0, request.item.cycles, 1'b0} + {2'b00, request.item.cycles};
            case (request.item.command)
              cbm_pkg::CMD_WRITE: begin
                if (request.item.address >= cbm_pkg::ADDR_REG_LO &&
                    request.item.address <= cbm_pkg::ADDR_REG_HI) begin
                  case (request.item.address)
                    cbm_pkg::ADDR_IRQ_ACK: begin
                      irq_flag <= 1'b0;
                    end
                    cbm_pkg::ADDR_TIMER_CTRL: begin
                      irq_flag      <= 1'b0;
                      timer_control <= request.item.data;
                      if ((request.item.data & cbm_pkg::TIMER_CLR_MASK) != 8'd0) begin
                        disk_counter <= 16'd0;
                      end
                    end
                    cbm_pkg::ADDR_COUNT_LO: begin
                      irq_flag <= 1'b0;
                      // Writing zero to the low byte clears the whole counter.
                      if (request.item.data == 8'd0) begin
                        countup_counter <= 16'd0;
                      end else begin
                        countup_counter <= {countup_counter[15:8], request.item.data};
                      end
                    end
                    cbm_pkg::ADDR_COUNT_HI: begin
                      irq_flag        <= 1'b0;
                      countup_counter <= {request.item.data, countup_counter[7:0]};
                    end
                    default: begin
                      if (request.item.address[15:2] == cbm_pkg::ADDR_MODE_ONE[15:2]) begin
                        mode_one <= {request.item.data[7:4], 2'b00,
                                     request.item.address[1:0]};
                      end else if (request.item.address[15:2] ==
                                   cbm_pkg::ADDR_MODE_TWO[15:2]) begin
                        mode_two     <= {request.item.data[7:4], 2'b00,
                                         request.item.address[1:0]};
                        chr_bank_reg <= request.item.data[1:0];
                      end
                    end
                  endcase
                end else if (request.item.address[15]) begin
                  if (mode_one[1]) begin
                    data_latch <= request.item.data;
                    bank_regs[request.item.address[14:13]] <= bank_value[BANK_BITS-1:0];
                    case (mode_one[7:5]) inside
                      cbm_pkg::MODE_32K_MID, cbm_pkg::MODE_32K_QUAD, cbm_pkg::MODE_FIXED:
                        chr_bank_reg <= request.item.data[1:0];
                      cbm_pkg::MODE_16K_TOP:
                        chr_bank_reg <= request.item.data[5:4];
                      default: begin
                      end
                    endcase
                  end else begin
                    wt_pending <= 1'b1;
                  end
                end
              end
              cbm_pkg::CMD_POWER_UP: begin
                mode_one        <= {variant, ~vertical, 4'b0011};
                mode_two        <= 8'h03;
                bank_regs[0]    <= BANK_BITS'(8'h1C);
                bank_regs[1]    <= BANK_BITS'(8'h1D);
                bank_regs[2]    <= BANK_BITS'(8'h1E);
                bank_regs[3]    <= BANK_BITS'(8'h1F);
                chr_bank_reg    <= 2'd0;
                data_latch      <= 8'd0;
                timer_control   <= 8'd0;
                disk_counter    <= 16'd0;
                countup_counter <= 16'd0;
                irq_flag        <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        cbm_pkg::ST_DISK: begin
          disk_counter <= alu_res[15:0];
          mod_step     <= cbm_pkg::MOD_STEPS_TOP;
          if (disk_fire) begin
            irq_flag <= 1'b1;
          end
        end
        cbm_pkg::ST_MOD: begin
          // Restoring step: keep the difference when no borrow comes out.
          if (!alu_res[16]) begin
            disk_counter <= alu_res[15:0];
          end
          mod_step <= mod_step - 3'd1;
        end
        cbm_pkg::ST_CUP: begin
          // The count-up timer runs only while negative and fires once it is no longer negative.
          if (countup_counter[15]) begin
            countup_counter <= alu_res[15:0];
            if (!alu_res[15]) begin
              irq_flag <= 1'b1;
            end
          end
        end
        cbm_pkg::ST_FIN: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Program slot mapping for the result item.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      bank_wide[i] = 8'(bank_regs[i]);
    end
    slot[0] = bank_wide[0][5:0];
    slot[1] = bank_wide[1][5:0];
    slot[2] = bank_wide[2][5:0];
    slot[3] = bank_wide[3][5:0];
    if (mode_two[0]) begin
      slot[2] = 6'd14;
      slot[3] = 6'd15;
      unique case (mode_one[7:5])
        cbm_pkg::MODE_32K_LOW: begin
          slot[0] = {2'b00, data_latch[2:0], 1'b0};
          slot[1] = {2'b00, data_latch[2:0], 1'b1};
        end
        cbm_pkg::MODE_32K_MID: begin
          slot[0] = {1'b0, data_latch[5:2], 1'b0};
          slot[1] = {1'b0, data_latch[5:2], 1'b1};
        end
        cbm_pkg::MODE_16K_HIGH: begin
          slot[0] = {1'b0, data_latch[3:0], 1'b0};
          slot[1] = {1'b0, data_latch[3:0], 1'b1};
          slot[2] = 6'd30;
          slot[3] = 6'd31;
        end
        cbm_pkg::MODE_16K_TOP: begin
          slot[0] = 6'd30;
          slot[1] = 6'd31;
          slot[2] = {1'b0, data_latch[3:0], 1'b0};
          slot[3] = {1'b0, data_latch[3:0], 1'b1};
        end
        cbm_pkg::MODE_32K_QUAD: begin
          slot[0] = {2'b00, data_latch[5:4], 2'b00};
          slot[1] = {2'b00, data_latch[5:4], 2'b01};
          slot[2] = {2'b00, data_latch[5:4], 2'b10};
          slot[3] = {2'b00, data_latch[5:4], 2'b11};
        end
        cbm_pkg::MODE_FIXED: begin
          slot[0] = 6'd12;
          slot[1] = 6'd13;
        end
        cbm_pkg::MODE_NIBBLE: begin
          slot[0] = {2'b00, data_latch[3:0]};
          slot[1] = {2'b00, data_latch[7:4]};
        end
        cbm_pkg::MODE_NIBBLE_E: begin
          slot[0] = {2'b00, data_latch[3:1], 1'b0};
          slot[1] = {2'b00, data_latch[7:5], 1'b1};
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == cbm_pkg::ST_FIN && (!rsp_valid || result.ready)) begin
      rsp_valid <= 1'b1;
    end else if (result.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == cbm_pkg::ST_FIN && (!rsp_valid || result.ready)) begin
      rsp_item.prg_bank_slot0 <= slot[0] & SLOT_MASK;
      rsp_item.prg_bank_slot1 <= slot[1] & SLOT_MASK;
      rsp_item.prg_bank_slot2 <= slot[2] & SLOT_MASK;
      rsp_item.prg_bank_slot3 <= slot[3] & SLOT_MASK;
      rsp_item.prg_wr_en      <= ~mode_one[1];
      rsp_item.chr_bank       <= chr_bank_reg;
      rsp_item.chr_wr_en      <= ~mode_one[7];
      rsp_item.mirroring      <= {mode_one[4], mode_one[0]};
      rsp_item.irq            <= irq_flag;
      rsp_item.write_through  <= wt_pending;
    end
  end

`ifndef SYNTH
  a_direct_to_fin: assert property (@(posedge clk) disable iff (rst)
    accept && request.item.command != cbm_pkg::CMD_TICK |=> state == cbm_pkg::ST_FIN)
    else $error("non-tick item did not go straight to the result stage");

  a_mod_positive: assert property (@(posedge clk) disable iff (rst)
    state == cbm_pkg::ST_MOD |-> !disk_counter[15])
    else $error("disk counter negative during reduction");

  a_mod_done: assert property (@(posedge clk) disable iff (rst)
    $past(state) == cbm_pkg::ST_MOD && state == cbm_pkg::ST_CUP |->
      disk_counter < cbm_pkg::DISK_MOD)
    else $error("disk counter not reduced below 448");

  a_power_up_irq: assert property (@(posedge clk) disable iff (rst)
    accept && request.item.command == cbm_pkg::CMD_POWER_UP |=> !irq_flag)
    else $error("interrupt still raised after power-up");
`endif

endmodule
`default_nettype wire

### bench/tb_cartridge_bank_mapper_with_irq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cartridge_bank_mapper_with_irq: self-checking bench for the bank mapper
// Feeds bus writes, cycle ticks and power-up items through the request
// channel and checks every result item against a behavioral copy of the
// mapper or a fixed view from the directed table, over several board settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_cartridge_bank_mapper_with_irq;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_PER_PHASE = 140;
  localparam int MAX_PRINTS = 50;

  typedef struct {
    cbm_pkg::req_item_t req;
    bit                 typed;
    cbm_pkg::rsp_item_t want;
  } dir_row_t;

  localparam cbm_pkg::rsp_item_t RESET_VIEW =
    '{6'd0, 6'd1, 6'd14, 6'd15, 1'b0, 2'd0, 1'b1, 2'd1, 1'b0, 1'b0};
  localparam cbm_pkg::rsp_item_t OPEN_VIEW =
    '{6'd14, 6'd15, 6'd14, 6'd15, 1'b1, 2'd0, 1'b1, 2'd0, 1'b0, 1'b0};
  localparam cbm_pkg::rsp_item_t THROUGH_VIEW =
    '{6'd14, 6'd15, 6'd14, 6'd15, 1'b1, 2'd0, 1'b1, 2'd0, 1'b0, 1'b1};

  logic clk;
  logic rst;
  logic cfg_write;
  logic cfg_index;
  logic [2:0] cfg_data;

  cbm_req_if req_ch ();
  cbm_rsp_if rsp_ch ();

  cartridge_bank_mapper_with_irq uut (
    .clk      (clk),
    .rst      (rst),
    .request  (req_ch),
    .result   (rsp_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Behavioral copy of the mapper state and its board settings.
  logic [2:0]  cfg_variant;
  logic        cfg_vertical;
  logic [7:0]  bank_mode_reg;
  logic [7:0]  aux_mode_reg;
  logic [5:0]  prg_regs [4];
  logic [1:0]  chr_reg;
  logic [7:0]  latch_byte;
  logic [7:0]  timer_ctl;
  logic [15:0] disk_count;
  logic [15:0] up_count;
  logic        irq_pending;

  cbm_pkg::rsp_item_t pending_views [$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  dir_row_t dir_table [24] = '{
    '{'{CMD_UNUSED, 16'hFFFF, 8'hFF, 10'h3FF}, 1'b1, RESET_VIEW},
    '{'{cbm_pkg::CMD_WRITE, 16'h8000, 8'hFF, 10'd0}, 1'b0, '0},
    '{'{cbm_pkg::CMD_WRITE, 16'h42FC, 8'h00, 10'd0}, 1'b1, OPEN_VIEW},
    '{'{cbm_pkg::CMD_WRITE, 16'hFFFF, 8'h55, 10'd0}, 1'b1, THROUGH_VIEW},
    '{'{cbm_pkg::CMD_WRITE, 16'h42FF, 8'hF0, 10'd0}, 1'b0, '0},
    '{'{cbm_pkg::CMD_WRITE, 16'hA000, 8'h00, 10'd0}, 1'b0, '0},
    '{'{cbm_pkg::CMD_WRITE, 16'hC000, 8'h80, 10'd0}, 1'b0, '0},
    '{'{cbm_pkg::CMD_WRITE, 16'hE000, 8'hFF, 10'd0}, 1'b0, '0},
    '{'{cbm_pkg::CMD_WRITE, 16'h43FC, 8'h03, 10'd0}, 1'b0, '0},
    '{'{cbm_pkg::CMD_WRITE, 16'h43FF, 8'hF2, 10'd0}, 1'b0, '0},
    '{'{cbm_pkg::CMD_WRITE, 16'h42FE, 8'h20, 10'd0}, 1'b0, '0},
    '{'{cbm_pkg::CMD_WRITE, 16'h8000, 8'h3C, 10'd0}, 1'b0, '0},
    '{'{cbm_pkg::CMD_WRITE, 16'h4025, 8'hC2, 10'd0}, 1'b0, '0},
    '{'{cbm_pkg::CMD_TICK, 16'h0000, 8'h00, 10'h3FF}, 1'b0, '0},
    '{'{cbm_pkg::CMD_WRITE, 16'h4024, 8'h00, 10'd0}, 1'b0, '0},
    '{'{cbm_pkg::CMD_WRITE, 16'h4101, 8'hFF, 10'd0}, 1'b0, '0},
    '{'{cbm_pkg::CMD_WRITE, 16'h4100, 8'hF0, 10'd0}, 1'b0, '0},
    '{'{cbm_pkg::CMD_TICK, 16'h0000, 8'h00, 10'd10}, 1'b0, '0},
    '{'{cbm_pkg::CMD_TICK, 16'h0000, 8'h00, 10'd6}, 1'b0, '0},
    '{'{cbm_pkg::CMD_WRITE, 16'h4100, 8'h00, 10'd0}, 1'b0, '0},
    '{'{cbm_pkg::CMD_WRITE, 16'h0000, 8'hFF, 10'd0}, 1'b0, '0},
    '{'{cbm_pkg::CMD_WRITE, 16'h7FFF, 8'hAA, 10'd0}, 1'b0, '0},
    '{'{cbm_pkg::CMD_WRITE, 16'h47FF, 8'hFF, 10'd0}, 1'b0, '0},
    '{'{cbm_pkg::CMD_POWER_UP, 16'h0000, 8'h00, 10'd0}, 1'b1, RESET_VIEW}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void power_up_state();
    bank_mode_reg = {cfg_variant, 5'b0} | (cfg_vertical ? 8'h01 : 8'h11) | 8'h02;
    aux_mode_reg = 8'h03;
    prg_regs = '{6'h1C, 6'h1D, 6'h1E, 6'h1F};
    chr_reg = '0;
    latch_byte = '0;
    timer_ctl = '0;
    disk_count = '0;
    up_count = '0;
    irq_pending = 1'b0;
  endfunction

  // Applies one item to the copy of the mapper and returns the view it shows.
  function automatic cbm_pkg::rsp_item_t mapper_view(input cbm_pkg::req_item_t it);
    cbm_pkg::rsp_item_t r;
    logic [7:0] b [4];
    logic [15:0] a;
    logic [7:0] v;
    logic through;
    int s;
    a = it.address;
    v = it.data;
    through = 1'b0;
    case (it.command)
      cbm_pkg::CMD_WRITE: begin
        if (a >= cbm_pkg::ADDR_REG_LO && a <= cbm_pkg::ADDR_REG_HI) begin
          if (a == cbm_pkg::ADDR_IRQ_ACK) begin
            irq_pending = 1'b0;
          end else if (a == cbm_pkg::ADDR_TIMER_CTRL) begin
            irq_pending = 1'b0;
            timer_ctl = v;
            if ((v & cbm_pkg::TIMER_CLR_MASK) != 0) disk_count = '0;
          end else if (a == cbm_pkg::ADDR_COUNT_LO) begin
            irq_pending = 1'b0;
            // A zero low byte clears the whole count-up counter.
            up_count = (v == 8'h00) ? 16'h0000 : {up_count[15:8], v};
          end else if (a == cbm_pkg::ADDR_COUNT_HI) begin
            irq_pending = 1'b0;
            up_count[15:8] = v;
          end else if ({a[15:2], 2'b00} == cbm_pkg::ADDR_MODE_ONE) begin
            bank_mode_reg = {v[7:4], 2'b00, a[1:0]};
          end else if ({a[15:2], 2'b00} == cbm_pkg::ADDR_MODE_TWO) begin
            aux_mode_reg = {v[7:4], 2'b00, a[1:0]};
            chr_reg = v[1:0];
          end
        end else if (a[15]) begin
          if (bank_mode_reg[1]) begin
            latch_byte = v;
            prg_regs[a[14:13]] = v[7:2];
            case (bank_mode_reg[7:5])
              cbm_pkg::MODE_32K_MID, cbm_pkg::MODE_32K_QUAD, cbm_pkg::MODE_FIXED:
                chr_reg = v[1:0];
              cbm_pkg::MODE_16K_TOP: chr_reg = v[5:4];
              default: ;
            endcase
          end else begin
            through = 1'b1;
          end
        end
      end
      cbm_pkg::CMD_TICK: begin
        disk_count = disk_count + 16'(3 * int'(it.cycles));
        s = int'($signed(disk_count));
        if (timer_ctl[7] && s >= int'(cbm_pkg::DISK_MOD)) begin
          irq_pending = 1'b1;
          disk_count = 16'(s % int'(cbm_pkg::DISK_MOD));
        end
        // The count-up timer runs only while its value is negative.
        if (up_count[15]) begin
          s = int'($signed(up_count)) + int'(it.cycles);
          up_count = 16'(s);
          if (s >= 0) irq_pending = 1'b1;
        end
      end
      cbm_pkg::CMD_POWER_UP: power_up_state();
      default: ;
    endcase

    if (!aux_mode_reg[0]) begin
      for (int i = 0; i < 4; i++) b[i] = {2'b00, prg_regs[i]};
    end else begin
      b[2] = 8'd14;
      b[3] = 8'd15;
      case (bank_mode_reg[7:5])
        cbm_pkg::MODE_32K_LOW: begin
          b[0] = {4'h0, latch_byte[2:0], 1'b0};
          b[1] = b[0] + 8'd1;
        end
        cbm_pkg::MODE_32K_MID: begin
          b[0] = {3'b000, latch_byte[5:2], 1'b0};
          b[1] = b[0] + 8'd1;
        end
        cbm_pkg::MODE_16K_HIGH: begin
          b[0] = {3'b000, latch_byte[3:0], 1'b0};
          b[1] = b[0] + 8'd1;
          b[2] = 8'd30;
          b[3] = 8'd31;
        end
        cbm_pkg::MODE_16K_TOP: begin
          b[0] = 8'd30;
          b[1] = 8'd31;
          b[2] = {3'b000, latch_byte[3:0], 1'b0};
          b[3] = b[2] + 8'd1;
        end
        cbm_pkg::MODE_32K_QUAD: begin
          b[0] = {4'h0, latch_byte[5:4], 2'b00};
          b[1] = b[0] + 8'd1;
          b[2] = b[0] + 8'd2;
          b[3] = b[0] + 8'd3;
        end
        cbm_pkg::MODE_FIXED: begin
          b[0] = 8'd12;
          b[1] = 8'd13;
        end
        cbm_pkg::MODE_NIBBLE: begin
          b[0] = {4'h0, latch_byte[3:0]};
          b[1] = {4'h0, latch_byte[7:4]};
        end
        default: begin
          b[0] = {4'h0, latch_byte[3:1], 1'b0};
          b[1] = {4'h0, latch_byte[7:5], 1'b1};
        end
      endcase
    end

    r.prg_bank_slot0 = b[0][5:0];
    r.prg_bank_slot1 = b[1][5:0];
    r.prg_bank_slot2 = b[2][5:0];
    r.prg_bank_slot3 = b[3][5:0];
    r.prg_wr_en = ~bank_mode_reg[1];
    r.chr_bank = chr_reg;
    r.chr_wr_en = ~bank_mode_reg[7];
    r.mirroring = {bank_mode_reg[4], bank_mode_reg[0]};
    r.irq = irq_pending;
    r.write_through = through;
    return r;
  endfunction

  function automatic cbm_pkg::req_item_t random_item();
    cbm_pkg::req_item_t it;
    int pick;
    it.command = cbm_pkg::CMD_WRITE;
    it.address = 16'($urandom);
    it.data = 8'($urandom);
    it.cycles = 10'($urandom);
    pick = $urandom_range(99);
    if (pick < 30) begin
      it.address[15] = 1'b1;
    end else if (pick < 55) begin
      case ($urandom_range(5))
        0: it.address = cbm_pkg::ADDR_IRQ_ACK;
        1: it.address = cbm_pkg::ADDR_TIMER_CTRL;
        2: begin
          it.address = cbm_pkg::ADDR_COUNT_LO;
          if ($urandom_range(3) == 0) it.data = 8'h00;
        end
        3: it.address = cbm_pkg::ADDR_COUNT_HI;
        4: it.address = cbm_pkg::ADDR_MODE_ONE | 16'($urandom_range(3));
        default: it.address = cbm_pkg::ADDR_MODE_TWO | 16'($urandom_range(3));
      endcase
    end else if (pick < 85) begin
      it.command = cbm_pkg::CMD_TICK;
      if ($urandom_range(1) == 0) it.cycles = 10'($urandom_range(63));
    end else if (pick < 88) begin
      it.command = cbm_pkg::CMD_POWER_UP;
    end else if (pick < 90) begin
      it.command = CMD_UNUSED;
    end
    return it;
  endfunction

  task automatic report_failure(input string msg);
    if (mismatch_count < MAX_PRINTS) $display("FAIL at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want)
      report_failure($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input cbm_pkg::req_item_t it, input bit typed,
                           input cbm_pkg::rsp_item_t want);
    cbm_pkg::rsp_item_t calc;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.item = it;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    calc = mapper_view(it);
    pending_views.push_back(typed ? want : calc);
    @(negedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [2:0] val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_write = 1'b0;
    if (idx == cbm_pkg::CFG_BOARD_VARIANT) cfg_variant = val;
    else cfg_vertical = val[0];
  endtask

  task automatic drain();
    req_ch.valid = 1'b0;
    while (pending_views.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cbm_pkg::rsp_item_t got;
    cbm_pkg::rsp_item_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = rsp_ch.item;
      if (pending_views.size() == 0) begin
        report_failure("result item with no request pending");
      end else begin
        want = pending_views.pop_front();
        compare_field("prg_bank_slot0", got.prg_bank_slot0, want.prg_bank_slot0);
        compare_field("prg_bank_slot1", got.prg_bank_slot1, want.prg_bank_slot1);
        compare_field("prg_bank_slot2", got.prg_bank_slot2, want.prg_bank_slot2);
        compare_field("prg_bank_slot3", got.prg_bank_slot3, want.prg_bank_slot3);
        compare_field("prg_wr_en", got.prg_wr_en, want.prg_wr_en);
        compare_field("chr_bank", got.chr_bank, want.chr_bank);
        compare_field("chr_wr_en", got.chr_wr_en, want.chr_wr_en);
        compare_field("mirroring", got.mirroring, want.mirroring);
        compare_field("irq", got.irq, want.irq);
        compare_field("write_through", got.write_through, want.write_through);
      end
    end
  end

  // Ends the run if neither channel moves an item for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [2:0] variants [8];
    cbm_pkg::req_item_t it;
    variants = '{3'd0, 3'd7, 3'd3, 3'd5, 3'd1, 3'd6, 3'd2, 3'd4};
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.item = '0;
    rsp_ch.ready = 1'b1;
    cfg_write = 1'b0;
    cfg_index = cbm_pkg::CFG_BOARD_VARIANT;
    cfg_data = '0;
    cfg_variant = 3'd0;
    cfg_vertical = 1'b1;
    power_up_state();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_table[i]) send_item(dir_table[i].req, dir_table[i].typed, dir_table[i].want);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      write_cfg(cbm_pkg::CFG_BOARD_VARIANT, variants[phase]);
      write_cfg(cbm_pkg::CFG_VERTICAL, {2'b00, phase[0]});
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 75; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 75; end
        default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
      // Start each phase from the new board setting.
      it = '0;
      it.command = cbm_pkg::CMD_POWER_UP;
      send_item(it, 1'b0, '0);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) send_item(random_item(), 1'b0, '0);
      drain();
    end

    if (mismatch_count == 0 && pending_views.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
